// ----- design/sm3_hash_core_defines.svh -----
// assertion macros for the sm3 hash core
// used by sm3_hash_core.sv, no other dependencies
`ifndef SM3_HASH_CORE_DEFINES_SVH
`define SM3_HASH_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define SM3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SM3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/sm3_pkg.sv -----
`timescale 1ns / 1ps
// sm3 package: initial value, round constants, rotate and permutation functions
// no dependencies
package sm3_pkg;
  typedef logic [31:0] word_t;

  localparam word_t IV0 = 32'h7380166F;
  localparam word_t IV1 = 32'h4914B2B9;
  localparam word_t IV2 = 32'h172442D7;
  localparam word_t IV3 = 32'hDA8A0600;
  localparam word_t IV4 = 32'hA96F30BC;
  localparam word_t IV5 = 32'h163138AA;
  localparam word_t IV6 = 32'hE38DEE4D;
  localparam word_t IV7 = 32'hB0FB0E4E;
  localparam word_t TJ_LOW  = 32'h79CC4519;
  localparam word_t TJ_HIGH = 32'h7A879D8A;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t iv_word(input logic [2:0] k);
    word_t r;
    case (k)
      3'd0: r = IV0;
      3'd1: r = IV1;
      3'd2: r = IV2;
      3'd3: r = IV3;
      3'd4: r = IV4;
      3'd5: r = IV5;
      3'd6: r = IV6;
      default: r = IV7;
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t p0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // round control from sequencer to round unit
  typedef struct packed {
    logic       load;   // load working variables from chain value
    logic       step;   // run one round
    logic       fold;   // xor working variables into chain value
    logic       init;   // return chain value to the initial value
    logic [5:0] rnd;
  } rnd_ctl_t;
endpackage

// ----- design/sm3_expand.sv -----
`timescale 1ns / 1ps
// sm3 message schedule: 16-word sliding window, one new w word per round
// depends on sm3_pkg
module sm3_expand import sm3_pkg::*; (
  input  logic  clk,
  input  logic  wr_en,
  input  word_t wr_word,
  input  logic  step,
  output word_t w0,
  output word_t w4
);
  word_t win_r [16];
  word_t win_nxt [16];
  word_t wn;

  // w[j+16] from the window w[j..j+15]
  assign wn = p1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 5'd15))
              ^ rotl(win_r[3], 5'd7) ^ win_r[10];
  assign w0 = win_r[0];
  assign w4 = win_r[4];

  always_comb begin
    for (int i = 0; i < 16; i++) win_nxt[i] = win_r[i];
    if (wr_en || step) begin
      for (int i = 0; i < 15; i++) win_nxt[i] = win_r[i+1];
      win_nxt[15] = wr_en ? wr_word : wn;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) win_r[i] <= win_nxt[i];
  end
endmodule

// ----- design/sm3_round.sv -----
`timescale 1ns / 1ps
// sm3 compression round unit with working variables and chain value
// depends on sm3_pkg
module sm3_round import sm3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rnd_ctl_t ctl,
  input  word_t    w0,
  input  word_t    w4,
  input  logic     shift_out,
  output word_t    cv0
);
  word_t v_r [8];
  word_t cv_r [8];
  word_t a12, tj, ss1, ss2, ff, gg, tt1, tt2;

  assign a12 = rotl(v_r[0], 5'd12);
  assign tj  = (ctl.rnd < 6'd16) ? TJ_LOW : TJ_HIGH;
  assign ss1 = rotl(a12 + v_r[4] + rotl(tj, ctl.rnd[4:0]), 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ff  = (ctl.rnd < 6'd16) ? (v_r[0] ^ v_r[1] ^ v_r[2])
             : ((v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]));
  assign gg  = (ctl.rnd < 6'd16) ? (v_r[4] ^ v_r[5] ^ v_r[6])
             : ((v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]));
  assign tt1 = ff + v_r[3] + ss2 + (w0 ^ w4);
  assign tt2 = gg + v_r[7] + ss1 + w0;
  assign cv0 = cv_r[0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= cv_r[i];
    end else if (ctl.step) begin
      v_r[0] <= tt1;
      v_r[1] <= v_r[0];
      v_r[2] <= rotl(v_r[1], 5'd9);
      v_r[3] <= v_r[2];
      v_r[4] <= p0(tt2);
      v_r[5] <= v_r[4];
      v_r[6] <= rotl(v_r[5], 5'd19);
      v_r[7] <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= iv_word(3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ v_r[i];
    end else if (shift_out) begin
      // rotate so the next digest word sits at the head
      for (int i = 0; i < 7; i++) cv_r[i] <= cv_r[i+1];
      cv_r[7] <= cv_r[0];
    end
  end
endmodule

// ----- design/sm3_hash_core.sv -----
`timescale 1ns / 1ps
// sm3 hash core top level: input sequencer, padding, digest output
// depends on sm3_pkg, sm3_expand, sm3_round, sm3_hash_core_defines.svh
//
//  channel  ports                                    dir
//  input    in_valid in_ready in_data_word
//           in_valid_bytes in_last                   in
//  result   out_valid out_ready out_digest_word
//           out_digest_last                          out
//
// a plain word is taken in S_IDLE; the 16th word of a block then runs
// load, 64 rounds on the shared round unit, and fold. a last word pads
// one word a cycle, runs one or two compressions, then shows 8 digest beats.
// reset brings the chain value to the initial value and clears counters.
// out_ready low simply holds the current digest beat.
`include "sm3_hash_core_defines.svh"
module sm3_hash_core import sm3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        fin_r, fin_nxt;     // padding in progress
  logic        xpad_r, xpad_nxt;   // 0x80 word still owed
  logic        lenok_r, lenok_nxt; // length words fit in the current block
  logic        final_blk_r;
  logic        wr_en;
  word_t       wr_word, w0, w4, cv0, pad_word, in_mask;
  rnd_ctl_t    ctl;
  logic        accept, shift_out;
  logic [2:0]  nb;
  logic [5:0]  pshift;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign shift_out = out_valid && out_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_digest_word = cv0;
  assign out_digest_last = (oidx_r == 3'd7);

  assign nb = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
  assign pshift = 6'd32 - {nb, 3'b000};
  assign in_mask = (nb == 3'd0) ? 32'h0 : word_t'(33'h1_0000_0000 - (33'h1 << pshift));
  assign pad_word = (in_data_word & in_mask)
                  | word_t'({24'h0, PAD_BYTE} << (6'd24 - {nb, 3'b000}));

  sm3_expand u_exp (
    .clk(clk), .wr_en(wr_en), .wr_word(wr_word), .step(ctl.step), .w0(w0), .w4(w4)
  );
  sm3_round u_rnd (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .w0(w0), .w4(w4),
    .shift_out(shift_out), .cv0(cv0)
  );

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    fin_nxt   = fin_r;
    xpad_nxt  = xpad_r;
    lenok_nxt = lenok_r;
    wr_en     = 1'b0;
    wr_word   = in_data_word;
    ctl       = '0;
    ctl.rnd   = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          wr_en = 1'b1;
          if (!in_last) begin
            bits_nxt = bits_r + 64'd32;
          end else begin
            bits_nxt = bits_r + {58'h0, nb, 3'b000};
            fin_nxt  = 1'b1;
            xpad_nxt = (nb == 3'd4);
            // marker in word 14 or 15 pushes the length into one more block
            lenok_nxt = (nb != 3'd4) && (fill_r < 4'd14);
            if (nb != 3'd4) wr_word = pad_word;
          end
          fill_nxt = fill_r + 4'd1;
          if (fill_r == 4'd15) state_nxt = S_LOAD;
          else if (in_last) state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        wr_en = 1'b1;
        if (xpad_r) begin
          wr_word = {PAD_BYTE, 24'h0};
          lenok_nxt = (fill_r < 4'd14);
        end else if (lenok_r && fill_r == 4'd14) begin
          wr_word = bits_r[63:32];
        end else if (lenok_r && fill_r == 4'd15) begin
          wr_word = bits_r[31:0];
        end else begin
          wr_word = '0;
        end
        xpad_nxt = 1'b0;
        fill_nxt = fill_r + 4'd1;
        if (fill_r == 4'd15) begin
          state_nxt = S_LOAD;
          if (lenok_r && !xpad_r) fin_nxt = 1'b0;
        end
      end
      S_LOAD: begin
        ctl.load = 1'b1;
        rnd_nxt = '0;
        state_nxt = S_RND;
      end
      S_RND: begin
        ctl.step = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
        if (fin_r) begin
          state_nxt = S_PAD;
          lenok_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
        // the length word marks the final block of a message
        if (final_blk_r) begin
          state_nxt = S_OUT;
          oidx_nxt = '0;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            state_nxt = S_IDLE;
            ctl.init = 1'b1;
            bits_nxt = '0;
            fill_nxt = '0;
            lenok_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // set when the length words went into the block being compressed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_blk_r <= 1'b0;
    end else if (state_r == S_PAD && fill_r == 4'd15 && lenok_r && !xpad_r) begin
      final_blk_r <= 1'b1;
    end else if (state_r == S_OUT) begin
      final_blk_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      xpad_r  <= 1'b0;
      lenok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      fin_r   <= fin_nxt;
      xpad_r  <= xpad_nxt;
      lenok_r <= lenok_nxt;
    end
  end

  `SM3_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready, "ready while busy")
  `SM3_ASSERT_NXT(a_rounds_end, clk, rst_n, state_r == S_RND && rnd_r == 6'd63, state_r == S_FOLD, "round count slip")
  `SM3_ASSERT_IMP(a_last_beat, clk, rst_n, out_valid && out_digest_last, oidx_r == 3'd7, "digest last misplaced")
endmodule
